// ===== hw/rtl/mpfb_pkg.sv =====
`default_nettype none
package mpfb_pkg;

   localparam int PANEL_WIDTH  = 128;
   localparam int PANEL_HEIGHT = 64;
   localparam int PAGE_ROWS    = 8;
   localparam int PAGE_COUNT   = (PANEL_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
   localparam int STORE_BYTES  = PANEL_WIDTH * PAGE_COUNT;
   localparam int ADDR_W       = $clog2(STORE_BYTES);
   localparam int BIT_W        = $clog2(PAGE_ROWS);
   localparam int X_W          = 8;
   localparam int Y_W          = 7;
   localparam int REQ_DATA_W   = 24;
   localparam int RSP_DATA_W   = 8;

   // queue depth, power of two
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic       OP_PLOT   = 1'b0;
   localparam logic       OP_READ   = 1'b1;
   localparam logic [1:0] MODE_COPY = 2'd0;
   localparam logic [1:0] MODE_SET  = 2'd1;
   localparam logic [1:0] MODE_XOR  = 2'd2;
   localparam logic [1:0] MODE_CLR  = 2'd3;

   typedef enum logic [1:0] {
      KIND_SET,
      KIND_TOGGLE,
      KIND_CLEAR,
      KIND_READ
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic                  in_range;
      logic [ADDR_W-1:0]     addr;
      logic [BIT_W-1:0]      bit_sel;
   } q_entry_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_FETCH,
      ST_MODIFY
   } back_state_type;

endpackage
`default_nettype wire

// ===== hw/rtl/mpfb_front.sv =====
`default_nettype none
module mpfb_front (
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [mpfb_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic                               req_tuser,
   input  wire logic                               busy,
   input  wire logic                               q_ready,
   output logic                                    q_push,
   output mpfb_pkg::q_entry_type                   q_entry
);

   logic [mpfb_pkg::X_W-1:0]   x;
   logic [mpfb_pkg::Y_W-1:0]   y;
   logic                       color;
   logic [1:0]                 mode;
   logic                       in_range;
   logic [mpfb_pkg::Y_W-1:0]   page;
   mpfb_pkg::kind_type         kind;

   assign x     = req_tdata[7:0];
   assign y     = req_tdata[14:8];
   assign color = req_tdata[15];
   assign mode  = req_tdata[17:16];
   assign page  = y >> mpfb_pkg::BIT_W;

   assign in_range = ({1'b0, x} < (mpfb_pkg::X_W+1)'(mpfb_pkg::PANEL_WIDTH)) &&
                     ({1'b0, y} < (mpfb_pkg::Y_W+1)'(mpfb_pkg::PANEL_HEIGHT));

   always_comb begin
      case (mode)
         mpfb_pkg::MODE_COPY: kind = color ? mpfb_pkg::KIND_SET : mpfb_pkg::KIND_CLEAR;
         mpfb_pkg::MODE_XOR:  kind = mpfb_pkg::KIND_TOGGLE;
         mpfb_pkg::MODE_CLR:  kind = mpfb_pkg::KIND_CLEAR;
         default:             kind = mpfb_pkg::KIND_SET;
      endcase
      if (req_tuser == mpfb_pkg::OP_READ) begin
         kind = mpfb_pkg::KIND_READ;
      end
   end

   always_comb begin
      q_entry.kind     = kind;
      q_entry.in_range = in_range;
      q_entry.bit_sel  = y[mpfb_pkg::BIT_W-1:0];
      if (in_range) begin
         q_entry.addr = mpfb_pkg::ADDR_W'(x) +
                        mpfb_pkg::ADDR_W'(page * mpfb_pkg::ADDR_W'(mpfb_pkg::PANEL_WIDTH));
      end else begin
         q_entry.addr = '0;
      end
   end

   assign req_tready = q_ready & ~busy;
   // out-of-panel plots are dropped here
   assign q_push = req_tvalid & req_tready & ((req_tuser == mpfb_pkg::OP_READ) | in_range);

endmodule
`default_nettype wire

// ===== hw/rtl/mpfb_queue.sv =====
`default_nettype none
module mpfb_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   output logic                        push_ready,
   input  wire mpfb_pkg::q_entry_type  push_entry,
   input  wire logic                   pop,
   output logic                        pop_valid,
   output mpfb_pkg::q_entry_type       pop_entry
);

   mpfb_pkg::q_entry_type              slot_ff [mpfb_pkg::QUEUE_DEPTH];
   logic [mpfb_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [mpfb_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [mpfb_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                               do_push;
   logic                               do_pop;

   assign push_ready = (count_ff != mpfb_pkg::QCNT_W'(mpfb_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push & push_ready;
   assign do_pop     = pop & pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/mpfb_back.sv =====
`default_nettype none
module mpfb_back (
   input  wire logic                               clock,
   input  wire logic                               reset,
   output logic                                    busy,
   input  wire logic                               q_valid,
   input  wire mpfb_pkg::q_entry_type              q_entry,
   output logic                                    q_pop,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [mpfb_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic                                    rsp_tuser
);

   logic [7:0]                     frame_mem [mpfb_pkg::STORE_BYTES];
   logic [7:0]                     rd_data_ff;

   mpfb_pkg::back_state_type       state_ff, state_in;
   logic [mpfb_pkg::ADDR_W-1:0]    clr_cnt_ff, clr_cnt_in;
   mpfb_pkg::q_entry_type          cur_ff, cur_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           pixel_ff, pixel_in;
   logic                           range_ff, range_in;

   logic                           rd_en;
   logic                           mem_we;
   logic [mpfb_pkg::ADDR_W-1:0]    mem_wa;
   logic [7:0]                     mem_wd;
   logic                           rsp_load;
   logic                           rsp_free;
   logic                           clr_last;
   logic [7:0]                     mask;

   assign rsp_free = ~rsp_valid_ff | rsp_tready;
   assign clr_last = (clr_cnt_ff == mpfb_pkg::ADDR_W'(mpfb_pkg::STORE_BYTES - 1));
   assign mask     = 8'(1) << cur_ff.bit_sel;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mpfb_pkg::ST_CLEAR: begin
            if (clr_last) state_in = mpfb_pkg::ST_FETCH;
         end
         mpfb_pkg::ST_FETCH: begin
            if (q_valid) state_in = mpfb_pkg::ST_MODIFY;
         end
         mpfb_pkg::ST_MODIFY: begin
            if (cur_ff.kind != mpfb_pkg::KIND_READ || rsp_free) state_in = mpfb_pkg::ST_FETCH;
         end
         default: state_in = mpfb_pkg::ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      busy     = 1'b0;
      q_pop    = 1'b0;
      rd_en    = 1'b0;
      mem_we   = 1'b0;
      mem_wa   = cur_ff.addr;
      mem_wd   = rd_data_ff;
      rsp_load = 1'b0;
      case (state_ff)
         mpfb_pkg::ST_CLEAR: begin
            busy   = 1'b1;
            mem_we = 1'b1;
            mem_wa = clr_cnt_ff;
            mem_wd = '0;
         end
         mpfb_pkg::ST_FETCH: begin
            q_pop = q_valid;
            rd_en = q_valid;
         end
         mpfb_pkg::ST_MODIFY: begin
            case (cur_ff.kind)
               mpfb_pkg::KIND_READ:   rsp_load = rsp_free;
               mpfb_pkg::KIND_TOGGLE: begin
                  mem_we = 1'b1;
                  mem_wd = rd_data_ff ^ mask;
               end
               mpfb_pkg::KIND_CLEAR: begin
                  mem_we = 1'b1;
                  mem_wd = rd_data_ff & ~mask;
               end
               default: begin
                  mem_we = 1'b1;
                  mem_wd = rd_data_ff | mask;
               end
            endcase
         end
         default: busy = 1'b1;
      endcase
   end

   always_comb begin
      clr_cnt_in   = (state_ff == mpfb_pkg::ST_CLEAR) ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
      cur_in       = q_pop ? q_entry : cur_ff;
      pixel_in     = pixel_ff;
      range_in     = range_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         pixel_in     = cur_ff.in_range & rd_data_ff[cur_ff.bit_sel];
         range_in     = cur_ff.in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mpfb_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      pixel_ff <= pixel_in;
      range_ff <= range_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= frame_mem[q_entry.addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(mpfb_pkg::RSP_DATA_W-1){1'b0}}, pixel_ff};
   assign rsp_tuser  = range_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/mono_page_framebuffer_pixel_ops_unit.sv =====
// Page-organized monochrome frame store with single-pixel plot (copy, set,
// toggle, clear) and read. Byte x + (y/8)*width holds the eight pixels of column x
// in page y/8, pixel y at bit y%8. Plots give no response; a read gives one response
// with the pixel in rsp_tdata[0] and the in-panel flag on rsp_tuser (pixel reads 0
// outside the panel). After reset the store's 1024 bytes are zeroed one byte per cycle,
// while req_tready stays low. Each queued transaction then passes through the
// back end as a registered memory read, then a write or response load (a read
// waits while the held response is not taken); the next is fetched only after that.
// Out-of-panel plots are dropped at the front. A 2-entry queue decouples the ends.
`default_nettype none
module mono_page_framebuffer_pixel_ops_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // [7:0] x, [14:8] y, [15] color, [17:16] mode, [23:18] zero
   input  wire logic [mpfb_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] op
   input  wire logic                               req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [0] pixel, [7:1] zero
   output logic [mpfb_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // [0] in_range
   output logic                                    rsp_tuser
);

   logic                       busy;
   logic                       push;
   logic                       push_ready;
   mpfb_pkg::q_entry_type      push_entry;
   logic                       pop;
   logic                       pop_valid;
   mpfb_pkg::q_entry_type      pop_entry;

   mpfb_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .busy       (busy),
      .q_ready    (push_ready),
      .q_push     (push),
      .q_entry    (push_entry)
   );

   mpfb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   mpfb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .busy       (busy),
      .q_valid    (pop_valid),
      .q_entry    (pop_entry),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire
